FILE: hdl/fvn_pkg.sv
// ----------------------------------------------------------------------------
// fvn_pkg
// Shared types, widths and constants for the fractal value-noise pipeline.
// ----------------------------------------------------------------------------
package fvn_pkg;

  localparam int MAX_OCTAVES = 8;
  localparam int COORD_BITS  = 12;
  localparam int TILE_W      = 12;
  localparam int ELEV_W      = 16;

  localparam int OCT_W       = $clog2(MAX_OCTAVES + 1);
  localparam int AMP_W       = 17;
  localparam int AMP_SUM_W   = $clog2(MAX_OCTAVES * 65536 + 1);
  localparam int ACC_W       = 48 + $clog2(MAX_OCTAVES);
  localparam int SCX_W       = COORD_BITS + 32;
  localparam int DIV_W       = AMP_SUM_W + 15;
  localparam int MAG_W       = ACC_W + 1;
  localparam int QBITS       = 16;

  localparam logic [31:0] HASH_MUL_Y   = 32'd57;
  localparam logic [31:0] HASH_MUL_S   = 32'd131;
  localparam logic [31:0] HASH_C1      = 32'd15731;
  localparam logic [31:0] HASH_C2      = 32'd789221;
  localparam logic [31:0] HASH_C3      = 32'd1376312589;
  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
  localparam logic [17:0] SMOOTH_3     = 18'd196608;
  localparam logic [AMP_W-1:0] AMP_ONE = AMP_W'(65536);

  typedef enum logic [2:0] {
    REG_SEED        = 3'd0,
    REG_OCTAVES     = 3'd1,
    REG_BASE_FREQ   = 3'd2,
    REG_AMP_DECAY   = 3'd3,
    REG_FREQ_GROWTH = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0]      seed;
    logic [OCT_W-1:0] oct_eff;
    logic [15:0]      decay;
    logic [15:0]      growth;
  } oct_cfg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0]   tx;
    logic [COORD_BITS-1:0]   ty;
    logic [31:0]             freq;
    logic [AMP_W-1:0]        amp;
    logic signed [ACC_W-1:0] acc;
    logic [AMP_SUM_W-1:0]    amp_sum;
  } oct_ctx_t;

  // floor((lo*(1-s) + hi*s)), s in Q0.16
  function automatic logic signed [31:0] lerp(input logic signed [31:0] lo,
                                               input logic signed [31:0] hi,
                                               input logic [15:0] s);
    logic signed [17:0] w1;
    logic signed [17:0] w0;
    logic signed [50:0] sum;
    w1  = signed'({2'b00, s});
    w0  = 18'sd65536 - w1;
    sum = 51'(lo * w0) + 51'(hi * w1);
    return sum[47:16];
  endfunction

endpackage

FILE: hdl/fvn_octave.sv
// ----------------------------------------------------------------------------
// fvn_octave
// One octave: lattice hash of four corners, smoothstep blend, weighted add.
// ----------------------------------------------------------------------------
module fvn_octave (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  fvn_pkg::oct_cfg_t   cfg,
  input  logic [fvn_pkg::OCT_W-1:0] oct_idx,
  input  logic                in_valid,
  input  fvn_pkg::oct_ctx_t   in_ctx,
  output logic                out_valid,
  output fvn_pkg::oct_ctx_t   out_ctx
);
  import fvn_pkg::*;

  logic [8:0] vld;
  oct_ctx_t   ctx_q [8];
  logic [31:0]      nf_q [1:7];
  logic [AMP_W-1:0] na_q [1:7];

  logic [SCX_W-1:0] cx0, cy0;
  logic [47:0]      fp0;
  logic [32:0]      ap0;

  logic [31:0] n1 [4];
  logic [15:0] tfx1, tfy1;
  logic [31:0] t2x1, t2y1;

  logic [31:0] n2 [4];
  logic [31:0] nn2 [4];
  logic [15:0] sx2, sy2;

  logic [31:0] n3 [4];
  logic [31:0] p3 [4];
  logic [15:0] sx3, sy3;

  logic [30:0] m4 [4];
  logic [15:0] sx4, sy4;

  logic signed [31:0] a5, b5;
  logic [15:0]        sy5;
  logic signed [31:0] nv6;
  logic signed [49:0] pr7;

  // combinational
  logic [31:0] xi, yi, seed_o, base;
  logic [31:0] n1_c [4];
  logic [31:0] nf1_c;
  logic [49:0] sxf_c, syf_c;
  logic signed [31:0] v5_c [4];
  logic active;

  always_comb begin
    xi     = 32'(cx0[SCX_W-1:16]);
    yi     = 32'(cy0[SCX_W-1:16]);
    seed_o = cfg.seed + 32'(oct_idx);
    base   = seed_o * HASH_MUL_S;
    for (int k = 0; k < 4; k++) begin
      logic [31:0] h;
      h = (xi + 32'(k % 2)) + (yi + 32'(k / 2)) * HASH_MUL_Y + base;
      n1_c[k] = (h << 13) ^ h;
    end
    nf1_c = (fp0[47:44] != 4'd0) ? 32'hFFFF_FFFF : fp0[43:12];
    sxf_c = 50'(t2x1 * (SMOOTH_3 - {1'b0, tfx1, 1'b0}));
    syf_c = 50'(t2y1 * (SMOOTH_3 - {1'b0, tfy1, 1'b0}));
    for (int k = 0; k < 4; k++) begin
      v5_c[k] = ONE_Q30 - signed'({1'b0, m4[k]});
    end
    active = OCT_W'(oct_idx) < cfg.oct_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[7:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_q[0] <= in_ctx;
      for (int k = 1; k < 8; k++) ctx_q[k] <= ctx_q[k-1];
      nf_q[1] <= nf1_c;
      na_q[1] <= ap0[32:16];
      for (int k = 2; k < 8; k++) begin
        nf_q[k] <= nf_q[k-1];
        na_q[k] <= na_q[k-1];
      end

      cx0 <= SCX_W'(in_ctx.tx * in_ctx.freq);
      cy0 <= SCX_W'(in_ctx.ty * in_ctx.freq);
      fp0 <= 48'(in_ctx.freq * cfg.growth);
      ap0 <= 33'(in_ctx.amp * cfg.decay);

      tfx1 <= cx0[15:0];
      tfy1 <= cy0[15:0];
      t2x1 <= 32'(cx0[15:0] * cx0[15:0]);
      t2y1 <= 32'(cy0[15:0] * cy0[15:0]);
      sx2  <= sxf_c[47:32];
      sy2  <= syf_c[47:32];
      sx3  <= sx2;
      sy3  <= sy2;
      sx4  <= sx3;
      sy4  <= sy3;
      for (int k = 0; k < 4; k++) begin
        n1[k]  <= n1_c[k];
        n2[k]  <= n1[k];
        nn2[k] <= n1[k] * n1[k];
        n3[k]  <= n2[k];
        p3[k]  <= nn2[k] * HASH_C1 + HASH_C2;
        m4[k]  <= 31'(n3[k] * p3[k] + HASH_C3);
      end

      a5  <= lerp(v5_c[0], v5_c[1], sx4);
      b5  <= lerp(v5_c[2], v5_c[3], sx4);
      sy5 <= sy4;
      nv6 <= lerp(a5, b5, sy5);
      pr7 <= nv6 * signed'({1'b0, ctx_q[6].amp});

      out_ctx.tx      <= ctx_q[7].tx;
      out_ctx.ty      <= ctx_q[7].ty;
      out_ctx.freq    <= nf_q[7];
      out_ctx.amp     <= na_q[7];
      out_ctx.acc     <= ctx_q[7].acc + (active ? ACC_W'(pr7) : '0);
      out_ctx.amp_sum <= ctx_q[7].amp_sum +
                         (active ? AMP_SUM_W'(ctx_q[7].amp) : '0);
    end
  end

  assign out_valid = vld[8];

endmodule

FILE: hdl/fvn_div.sv
// ----------------------------------------------------------------------------
// fvn_div
// Pipelined restoring divide of the accumulator by the amplitude sum,
// truncated toward zero and saturated to Q1.15.
// ----------------------------------------------------------------------------
module fvn_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic signed [fvn_pkg::ACC_W-1:0]     in_acc,
  input  logic [fvn_pkg::AMP_SUM_W-1:0]        in_amp_sum,
  output logic                                 out_valid,
  output logic [fvn_pkg::ELEV_W-1:0]           out_q
);
  import fvn_pkg::*;

  logic [QBITS+1:0] vld;
  logic [MAG_W-1:0] rem [QBITS+1];
  logic [QBITS-1:0] quo [QBITS+1];
  logic [DIV_W-1:0] dvs [QBITS+1];
  logic             neg [QBITS+1];
  logic             ovf [1:QBITS];

  logic [MAG_W-1:0] dsh_c [QBITS];
  logic [MAG_W-1:0] dov_c;
  logic [QBITS-1:0] qm;

  always_comb begin
    for (int j = 0; j < QBITS; j++) begin
      dsh_c[j] = MAG_W'(dvs[j]) << (QBITS - 1 - j);
    end
    dov_c = MAG_W'(dvs[0]) << QBITS;
    qm    = quo[QBITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QBITS:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg[0] <= in_acc[ACC_W-1];
      rem[0] <= in_acc[ACC_W-1] ? MAG_W'(-$signed({in_acc[ACC_W-1], in_acc}))
                                : MAG_W'($signed({in_acc[ACC_W-1], in_acc}));
      dvs[0] <= {in_amp_sum, 15'd0};
      quo[0] <= '0;
      ovf[1] <= rem[0] >= dov_c;
      for (int j = 2; j <= QBITS; j++) ovf[j] <= ovf[j-1];
      for (int j = 0; j < QBITS; j++) begin
        neg[j+1] <= neg[j];
        dvs[j+1] <= dvs[j];
        if (rem[j] >= dsh_c[j]) begin
          rem[j+1] <= rem[j] - dsh_c[j];
          quo[j+1] <= quo[j] | (QBITS'(1) << (QBITS - 1 - j));
        end else begin
          rem[j+1] <= rem[j];
          quo[j+1] <= quo[j];
        end
      end
      if (neg[QBITS]) begin
        out_q <= (ovf[QBITS] || qm > 16'd32768) ? 16'h8000 : 16'(-qm);
      end else begin
        out_q <= (ovf[QBITS] || qm > 16'd32767) ? 16'h7FFF : qm;
      end
    end
  end

  assign out_valid = vld[QBITS+1];

endmodule

FILE: hdl/fractal_value_noise_2d.sv
// ----------------------------------------------------------------------------
// fractal_value_noise_2d
// Fractal value-noise elevation per tile coordinate, fully pipelined.
//
//   channel  dir  payload
//   s_axis   in   tdata[11:0] tile_x, tdata[23:12] tile_y
//   m_axis   out  tdata[15:0] elevation (signed Q1.15)
//   cfg      in   cfg_we/cfg_index/cfg_data, index 0..4
//
// One word per cycle sustained while m_axis is not stalled. Each word passes
// through MAX_OCTAVES octave stage blocks (all present) and then the divider.
// Reset (rst, synchronous) clears valid bits and loads register defaults.
// A stall on m_axis freezes the whole pipeline; s_axis_tready follows it.
// ----------------------------------------------------------------------------
module fractal_value_noise_2d (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // tile_x[11:0], tile_y[23:12]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // elevation[15:0]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import fvn_pkg::*;

  logic [31:0] noise_seed;
  logic [3:0]  octave_count;
  logic [23:0] base_frequency;
  logic [15:0] amplitude_decay;
  logic [15:0] frequency_growth;

  oct_cfg_t cfg;
  oct_ctx_t in_ctx;
  logic     en;

  logic     vchain [MAX_OCTAVES+1];
  oct_ctx_t cchain [MAX_OCTAVES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_seed       <= '0;
      octave_count     <= 4'd4;
      base_frequency   <= 24'd3277;
      amplitude_decay  <= 16'd32768;
      frequency_growth <= 16'd8192;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SEED:        noise_seed       <= cfg_data;
        REG_OCTAVES:     octave_count     <= cfg_data[3:0];
        REG_BASE_FREQ:   base_frequency   <= cfg_data[23:0];
        REG_AMP_DECAY:   amplitude_decay  <= cfg_data[15:0];
        REG_FREQ_GROWTH: frequency_growth <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.seed   = noise_seed;
    cfg.decay  = amplitude_decay;
    cfg.growth = frequency_growth;
    if (octave_count == 4'd0) begin
      cfg.oct_eff = OCT_W'(1);
    end else if (int'(octave_count) > MAX_OCTAVES) begin
      cfg.oct_eff = OCT_W'(MAX_OCTAVES);
    end else begin
      cfg.oct_eff = OCT_W'(octave_count);
    end

    in_ctx.tx      = s_axis_tdata[COORD_BITS-1:0];
    in_ctx.ty      = s_axis_tdata[TILE_W+COORD_BITS-1:TILE_W];
    in_ctx.freq    = 32'(base_frequency);
    in_ctx.amp     = AMP_ONE;
    in_ctx.acc     = '0;
    in_ctx.amp_sum = '0;
  end

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign vchain[0]     = s_axis_tvalid;
  assign cchain[0]     = in_ctx;

  for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_oct
    fvn_octave u_oct (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .cfg       (cfg),
      .oct_idx   (OCT_W'(g)),
      .in_valid  (vchain[g]),
      .in_ctx    (cchain[g]),
      .out_valid (vchain[g+1]),
      .out_ctx   (cchain[g+1])
    );
  end

  fvn_div u_div (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (vchain[MAX_OCTAVES]),
    .in_acc     (cchain[MAX_OCTAVES].acc),
    .in_amp_sum (cchain[MAX_OCTAVES].amp_sum),
    .out_valid  (m_axis_tvalid),
    .out_q      (m_axis_tdata)
  );

endmodule
